### hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

   localparam int unsigned LANES_DEFAULT   = 4;
   localparam int unsigned IN_FIELDS       = 4;
   localparam int unsigned UNIFORM_W       = 32;
   localparam int unsigned COUNT_W         = 8;
   localparam int unsigned LANE_W          = 2;
   localparam int unsigned REQ_DATA_W      = IN_FIELDS * UNIFORM_W;
   localparam int unsigned RSP_DATA_W      = 16;
   localparam int unsigned FIFO_DEPTH      = 2;
   localparam int unsigned FIFO_PTR_W      = 1;
   localparam int unsigned FIFO_CNT_W      = 2;

   localparam logic [UNIFORM_W-1:0] THRESHOLD_RESET = 32'd28939264;
   localparam logic [COUNT_W-1:0]   COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic               done;
      logic               sat;
      logic [COUNT_W-1:0] variate;
   } lane_res_type;

endpackage

`default_nettype wire

### hw/rtl/poisson_product_sampler_lanes_unit.sv
`default_nettype none

// Poisson sampler, product-of-uniforms method, one lane per uniform in
// req_tdata. An item is accepted every cycle while the two-entry result
// set queue has room; each lane does one 32x32 multiply and threshold
// compare per item, so the lane loop itself sustains one item per cycle.
// An item yields zero to four results, which leave one per cycle while
// rsp_tready is high, in ascending lane order through the single rsp
// port, so the sustained item rate is one per cycle as long as items
// average at most one result. An item's first result reaches rsp_tvalid
// in the cycle after its transfer when no earlier set is still queued.
module poisson_product_sampler_lanes_unit
   import pps_pkg::*;
#(
   parameter int unsigned LANES = LANES_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // uniform_lane0, uniform_lane1, uniform_lane2, uniform_lane3
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // lane, variate, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // saturated
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [UNIFORM_W-1:0]  csr_data
);

   localparam int unsigned ACTIVE = (LANES < IN_FIELDS) ? LANES : IN_FIELDS;

   logic [UNIFORM_W-1:0] threshold_ff, threshold_in;
   logic                 fire;
   logic                 full;
   logic                 any_done;
   lane_res_type         res [ACTIVE];
   logic [LANE_W-1:0]    lane_code;
   logic [COUNT_W-1:0]   variate;

   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign req_tready = !full;
   assign fire       = req_tvalid && req_tready;

   for (genvar g = 0; g < ACTIVE; g++) begin : g_lane
      pps_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .fire      (fire),
         .uniform   (req_tdata[g*UNIFORM_W +: UNIFORM_W]),
         .threshold (threshold_ff),
         .res       (res[g])
      );
   end

   always_comb begin
      any_done = 1'b0;
      for (int i = 0; i < ACTIVE; i++) begin
         any_done = any_done | res[i].done;
      end
   end

   pps_merge #(
      .ACTIVE (ACTIVE)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (fire && any_done),
      .res         (res),
      .full        (full),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_lane    (lane_code),
      .rsp_variate (variate),
      .rsp_sat     (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W-LANE_W-COUNT_W)'(0), variate, lane_code};

endmodule

`default_nettype wire

### hw/rtl/pps_lane.sv
`default_nettype none

module pps_lane
   import pps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [UNIFORM_W-1:0] uniform,
   input  wire logic [UNIFORM_W-1:0] threshold,
   output lane_res_type              res
);

   logic                   fresh_ff, fresh_in;
   logic [UNIFORM_W-1:0]   prod_ff, prod_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [2*UNIFORM_W-1:0] mult;
   logic [UNIFORM_W-1:0]   prod_new;
   logic                   below;

   assign mult     = (2*UNIFORM_W)'(prod_ff) * (2*UNIFORM_W)'(uniform);
   assign prod_new = fresh_ff ? uniform : mult[2*UNIFORM_W-1:UNIFORM_W];
   assign below    = prod_new < threshold;

   // variate is the count before this step in both endings
   always_comb begin
      res.done    = below || (count_ff == COUNT_MAX);
      res.sat     = !below && (count_ff == COUNT_MAX);
      res.variate = count_ff;
   end

   always_comb begin
      fresh_in = fresh_ff;
      prod_in  = prod_ff;
      count_in = count_ff;
      if (fire) begin
         if (res.done) begin
            fresh_in = 1'b1;
            count_in = '0;
         end else begin
            fresh_in = 1'b0;
            prod_in  = prod_new;
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         count_ff <= '0;
      end else begin
         fresh_ff <= fresh_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### hw/rtl/pps_merge.sv
`default_nettype none

module pps_merge
   import pps_pkg::*;
#(
   parameter int unsigned ACTIVE = LANES_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  lane_res_type               res [ACTIVE],
   output logic                       full,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [LANE_W-1:0]          rsp_lane,
   output logic [COUNT_W-1:0]         rsp_variate,
   output logic                       rsp_sat,
   output logic                       rsp_last
);

   lane_res_type            entry_ff [FIFO_DEPTH][ACTIVE];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [ACTIVE-1:0]       mask;
   logic [ACTIVE-1:0]       pick;
   logic                    xfer;
   logic                    pop;
   logic                    wr_en;

   always_comb begin
      for (int i = 0; i < ACTIVE; i++) begin
         mask[i] = entry_ff[rd_ptr_ff][i].done;
      end
   end

   // lowest pending lane first
   assign pick     = mask & (~mask + ACTIVE'(1));
   assign rsp_last = (mask & ~pick) == '0;

   always_comb begin
      rsp_lane    = '0;
      rsp_variate = '0;
      rsp_sat     = 1'b0;
      for (int i = 0; i < ACTIVE; i++) begin
         if (pick[i]) begin
            rsp_lane    = rsp_lane | LANE_W'(i);
            rsp_variate = rsp_variate | entry_ff[rd_ptr_ff][i].variate;
            rsp_sat     = rsp_sat | entry_ff[rd_ptr_ff][i].sat;
         end
      end
   end

   assign full       = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign rsp_tvalid = count_ff != '0;
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && rsp_last;
   assign wr_en      = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
      end
      unique case ({wr_en, pop})
         2'b10:   count_in = count_ff + FIFO_CNT_W'(1);
         2'b01:   count_in = count_ff - FIFO_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < FIFO_DEPTH; e++) begin
         for (int i = 0; i < ACTIVE; i++) begin
            if (wr_en && (wr_ptr_ff == FIFO_PTR_W'(e))) begin
               entry_ff[e][i] <= res[i];
            end else if (xfer && pick[i] && (rd_ptr_ff == FIFO_PTR_W'(e))) begin
               entry_ff[e][i].done <= 1'b0;
            end
         end
      end
   end

   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mask != '0))
      else $error("queued set has no pending lane");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("set queue overflow");

   a_rest_follows: assert property (@(posedge clock) disable iff (reset)
      (xfer && !rsp_last) |=> rsp_tvalid)
      else $error("set dropped before its last transfer");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import pps_pkg::*;
();

   localparam int unsigned              CYCLE_LIMIT = 400000;
   localparam logic [UNIFORM_W:0]       PRODUCT_ONE = {1'b1, {UNIFORM_W{1'b0}}};
   localparam logic [UNIFORM_W-1:0]     ALL_ONES    = {UNIFORM_W{1'b1}};
   localparam int unsigned              FILL_LSB    = LANE_W + COUNT_W;

   typedef struct {
      logic [LANE_W-1:0]  lane;
      logic [COUNT_W-1:0] variate;
      logic               saturated;
      logic               last;
   } draw_type;

   class poisson_scoreboard_type;
      logic [UNIFORM_W:0]   product [LANES_DEFAULT];
      logic [COUNT_W-1:0]   count [LANES_DEFAULT];
      logic [UNIFORM_W-1:0] threshold;
      draw_type             pending_draws [$];
      int unsigned          mismatches;

      function new();
         threshold  = THRESHOLD_RESET;
         mismatches = 0;
         foreach (product[i]) begin
            product[i] = PRODUCT_ONE;
            count[i]   = '0;
         end
      endfunction

      function void note_mismatch(input string text);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, text);
         end
      endfunction

      // one multiply per lane, finished draws queued in lane order
      function void note_uniforms(input logic [REQ_DATA_W-1:0] word);
         draw_type             fresh [$];
         draw_type             d;
         logic [63:0]          wide;
         logic [UNIFORM_W:0]   next_product;
         logic [UNIFORM_W-1:0] u;
         logic [COUNT_W:0]     k;
         for (int i = 0; i < LANES_DEFAULT; i++) begin
            u = word[i*UNIFORM_W +: UNIFORM_W];
            if (product[i] == PRODUCT_ONE) begin
               next_product = {1'b0, u};
            end else begin
               wide         = 64'(product[i]) * 64'(u);
               next_product = {1'b0, wide[63:32]};
            end
            k           = {1'b0, count[i]} + 1'b1;
            d.lane      = LANE_W'(i);
            d.last      = 1'b0;
            d.saturated = 1'b0;
            if (next_product < {1'b0, threshold}) begin
               d.variate = COUNT_W'(k - 1'b1);
               fresh.push_back(d);
               product[i] = PRODUCT_ONE;
               count[i]   = '0;
            end else if (k > {1'b0, COUNT_MAX}) begin
               d.variate   = COUNT_MAX;
               d.saturated = 1'b1;
               fresh.push_back(d);
               product[i] = PRODUCT_ONE;
               count[i]   = '0;
            end else begin
               product[i] = next_product;
               count[i]   = k[COUNT_W-1:0];
            end
         end
         foreach (fresh[j]) begin
            d      = fresh[j];
            d.last = (j == fresh.size() - 1);
            pending_draws.push_back(d);
         end
      endfunction

      function void check_draw(input logic [RSP_DATA_W-1:0] data, input logic sat,
                               input logic last);
         draw_type want;
         if (pending_draws.size() == 0) begin
            note_mismatch($sformatf("unexpected result lane %0d variate %0d sat %0b last %0b",
                                    data[LANE_W-1:0], data[LANE_W +: COUNT_W], sat, last));
            return;
         end
         want = pending_draws.pop_front();
         if (data[LANE_W-1:0] != want.lane || data[LANE_W +: COUNT_W] != want.variate ||
             sat != want.saturated || last != want.last ||
             data[RSP_DATA_W-1:FILL_LSB] != '0) begin
            note_mismatch($sformatf(
               {"expected lane %0d variate %0d sat %0b last %0b, ",
                "got lane %0d variate %0d sat %0b last %0b fill %0h"},
               want.lane, want.variate, want.saturated, want.last, data[LANE_W-1:0],
               data[LANE_W +: COUNT_W], sat, last, data[RSP_DATA_W-1:FILL_LSB]));
         end
      endfunction

      function int unsigned waiting();
         return pending_draws.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [UNIFORM_W-1:0]  csr_data;

   poisson_scoreboard_type sb;
   int unsigned            cycles;
   int unsigned            burst_left;
   int unsigned            stall_mode;
   int unsigned            stall_phase;

   poisson_product_sampler_lanes_unit #(
      .LANES(LANES_DEFAULT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver backpressure, mode redrawn whenever stall_phase wraps to zero
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      stall_phase = (stall_phase + 1) % 64;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (stall_phase % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_uniforms(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_draw(rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   end

   function automatic logic [REQ_DATA_W-1:0] lanes_word(input logic [UNIFORM_W-1:0] u0,
      input logic [UNIFORM_W-1:0] u1, input logic [UNIFORM_W-1:0] u2,
      input logic [UNIFORM_W-1:0] u3);
      return {u3, u2, u1, u0};
   endfunction

   function automatic logic [UNIFORM_W-1:0] random_uniform();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return ALL_ONES;
         2: return UNIFORM_W'($urandom_range(0, 255));
         3: return ALL_ONES - UNIFORM_W'($urandom_range(0, 255));
         default: return UNIFORM_W'($urandom);
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_word();
      return lanes_word(random_uniform(), random_uniform(), random_uniform(),
                        random_uniform());
   endfunction

   task automatic send_uniforms(input logic [REQ_DATA_W-1:0] word);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [UNIFORM_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      sb.threshold = value;
   endtask

   task automatic send_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         send_uniforms(random_word());
      end
   endtask

   initial begin
      sb          = new();
      cycles      = 0;
      burst_left  = 0;
      stall_mode  = 0;
      stall_phase = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset threshold
      send_uniforms(lanes_word('0, '0, '0, '0));
      repeat (3) send_uniforms(lanes_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_uniforms(lanes_word('0, '0, '0, '0));
      send_uniforms(lanes_word(THRESHOLD_RESET, THRESHOLD_RESET - 1'b1, 32'h8000_0000,
                               32'h0000_0001));
      send_uniforms(lanes_word(ALL_ONES, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555));
      send_uniforms(lanes_word(32'h5555_5555, 32'hAAAA_AAAA, ALL_ONES, 32'h0000_0001));
      send_uniforms(lanes_word(32'h0000_0001, ALL_ONES, 32'hFFFF_0000, 32'h0000_FFFF));
      repeat (4) send_uniforms(lanes_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000));

      send_random(12);
      wait_drained();
      send_random(12);

      // largest threshold: almost every draw ends at once
      write_threshold(ALL_ONES);
      send_random(6);
      // all lanes restart
      send_uniforms(lanes_word('0, '0, '0, '0));

      // zero threshold: every draw runs to the count limit
      write_threshold('0);
      send_random(256);

      // limit and threshold reached on the same multiplication
      write_threshold(ALL_ONES - UNIFORM_W'(254));
      repeat (256) send_uniforms(lanes_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));

      write_threshold(32'h0000_0001);
      send_random(4);
      write_threshold(UNIFORM_W'($urandom_range(0, 32'h00FF_FFFF)));
      send_random(4);
      write_threshold(UNIFORM_W'($urandom));
      send_random(4);
      write_threshold(THRESHOLD_RESET);
      send_random(4);

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.waiting() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

### poisson_product_sampler_lanes_unit.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_lane.sv
hw/rtl/pps_merge.sv
hw/rtl/poisson_product_sampler_lanes_unit.sv
sim/tb_top.sv
